// ===== rtl/dbtd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbtd_pkg
// Shared widths, table geometry and helpers for the double-byte text decoder.
// ----------------------------------------------------------------------------
package dbtd_pkg;

    localparam int KEY_W      = 16;
    localparam int TEXT_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int IDX_W      = 15;
    localparam int TBL_DEPTH  = 1 << IDX_W;
    localparam int ENTRY_W    = TEXT_W + 1;   // valid + text
    localparam int S_DATA_W   = 56;           // key, text, byte
    localparam int OB_CNT_W   = 3;            // 0..4 bytes left

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    typedef logic [BYTE_W-1:0] t_byte;

    // lower-case hex character for one nibble
    function automatic t_byte hex_char(input logic [3:0] nib);
        t_byte c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'h0, nib};
        end else begin
            c = 8'h57 + {4'h0, nib};
        end
        return c;
    endfunction

endpackage

// ===== rtl/dbtd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbtd_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module dbtd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/double_byte_text_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_byte_text_decoder
// Decodes a stream of double-byte encoded name bytes into text bytes.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 32768-entry code table clear, one entry per
// cycle, and accepts no transaction until the sweep is done. It then accepts
// one input transaction per cycle while stage 1 can move on: table writes
// (tuser 0) with key bit 15 set store an entry, data bytes (tuser 1) are
// decoded. The table lookup for a key comes out of the table RAM in the cycle
// after the partner byte is accepted; results then leave through an output
// buffer at one byte per cycle while the output is ready, so an input that
// gives more than one result byte holds the input side while the buffer drains
// (a key pair, two input bytes, gives at most four bytes).
// ----------------------------------------------------------------------------
module double_byte_text_decoder
    import dbtd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input stream
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,   // table_key[15:0], table_text[47:16],
                                             // data_byte[55:48]
    input  logic                i_s_tlast,   // end_of_name
    input  logic                i_s_tuser,   // opcode
    // output stream
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [BYTE_W-1:0]   o_m_tdata,   // out_byte[7:0]
    output logic                o_m_tlast,   // run_last
    output logic                o_m_tuser    // was_fallback
);

    // input fields
    logic [KEY_W-1:0]  s_key;
    logic [TEXT_W-1:0] s_text;
    t_byte             s_byte;
    logic              s_acc;

    assign s_key  = i_s_tdata[15:0];
    assign s_text = i_s_tdata[47:16];
    assign s_byte = i_s_tdata[55:48];
    assign s_acc  = i_s_tvalid && o_s_tready;

    // clearing sweep
    logic             r_clr_busy;
    logic [IDX_W-1:0] r_clr_addr;

    // decode state
    logic  r_lead_pending, n_lead_pending;
    t_byte r_lead_value,   n_lead_value;
    logic  r_name_stopped, n_name_stopped;

    // stage 1: waiting for table data
    logic             r_s1_valid, n_s1_valid;
    logic             r_s1_lookup, n_s1_lookup;
    logic [KEY_W-1:0] r_s1_key,   n_s1_key;

    // output buffer
    logic                r_ob_valid, n_ob_valid;
    logic [OB_CNT_W-1:0] r_ob_cnt,   n_ob_cnt;
    logic                r_ob_fb,    n_ob_fb;
    t_byte               r_ob_bytes [4];
    t_byte               n_ob_bytes [4];

    // table RAM
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic                dec_lookup;
    logic                dec_pass;
    logic                ob_take;
    logic                ob_free;
    logic                s1_go;
    logic [OB_CNT_W-1:0] s1_cnt;
    logic                s1_fb;
    t_byte               s1_bytes [4];

    dbtd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // which decode action this transaction takes
    always_comb begin
        dec_lookup = 1'b0;
        dec_pass   = 1'b0;
        if (s_acc && i_s_tuser == OP_DECODE && !r_name_stopped) begin
            if (r_lead_pending) begin
                dec_lookup = 1'b1;
            end else if (s_byte != 8'h00 && !s_byte[7]) begin
                dec_pass = 1'b1;
            end
        end
    end

    // table port: sweep writes zero, then table writes; reads only on lookups
    always_comb begin
        if (r_clr_busy) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = s_acc && i_s_tuser == OP_WRITE && s_key[15];
            ram_waddr = s_key[IDX_W-1:0];
            ram_wdata = {1'b1, s_text};
        end
        ram_re    = dec_lookup;
        ram_raddr = {r_lead_value[6:0], s_byte};
    end

    // stage 1 result bytes
    always_comb begin
        s1_bytes[0] = r_s1_key[7:0];
        s1_bytes[1] = 8'h00;
        s1_bytes[2] = 8'h00;
        s1_bytes[3] = 8'h00;
        s1_cnt      = 3'd1;
        s1_fb       = 1'b0;
        if (r_s1_lookup) begin
            if (ram_rdata[TEXT_W]) begin
                s1_bytes[0] = ram_rdata[7:0];
                s1_bytes[1] = ram_rdata[15:8];
                s1_bytes[2] = ram_rdata[23:16];
                s1_bytes[3] = ram_rdata[31:24];
                if (ram_rdata[7:0] == 8'h00) begin
                    s1_cnt = 3'd0;
                end else if (ram_rdata[15:8] == 8'h00) begin
                    s1_cnt = 3'd1;
                end else if (ram_rdata[23:16] == 8'h00) begin
                    s1_cnt = 3'd2;
                end else if (ram_rdata[31:24] == 8'h00) begin
                    s1_cnt = 3'd3;
                end else begin
                    s1_cnt = 3'd4;
                end
            end else begin
                // missed key: four hex characters, high nibble first
                s1_bytes[0] = hex_char(r_s1_key[15:12]);
                s1_bytes[1] = hex_char(r_s1_key[11:8]);
                s1_bytes[2] = hex_char(r_s1_key[7:4]);
                s1_bytes[3] = hex_char(r_s1_key[3:0]);
                s1_cnt      = 3'd4;
                s1_fb       = 1'b1;
            end
        end
    end

    assign ob_take    = r_ob_valid && i_m_tready;
    assign ob_free    = !r_ob_valid || (ob_take && r_ob_cnt == 3'd1);
    assign s1_go      = r_s1_valid && ob_free;
    assign o_s_tready = !r_clr_busy && (!r_s1_valid || s1_go);

    // next state
    always_comb begin
        n_lead_pending = r_lead_pending;
        n_lead_value   = r_lead_value;
        n_name_stopped = r_name_stopped;
        if (s_acc && i_s_tuser == OP_DECODE) begin
            if (!r_name_stopped) begin
                if (r_lead_pending) begin
                    n_lead_pending = 1'b0;
                end else if (s_byte == 8'h00) begin
                    n_name_stopped = 1'b1;
                end else if (s_byte[7]) begin
                    n_lead_pending = 1'b1;
                    n_lead_value   = s_byte;
                end
            end
            if (i_s_tlast) begin
                n_lead_pending = 1'b0;
                n_name_stopped = 1'b0;
            end
        end

        n_s1_valid  = r_s1_valid && !s1_go;
        n_s1_lookup = r_s1_lookup;
        n_s1_key    = r_s1_key;
        if (dec_lookup || dec_pass) begin
            n_s1_valid  = 1'b1;
            n_s1_lookup = dec_lookup;
            n_s1_key    = dec_lookup ? {r_lead_value, s_byte} : {8'h00, s_byte};
        end

        n_ob_valid = r_ob_valid;
        n_ob_cnt   = r_ob_cnt;
        n_ob_fb    = r_ob_fb;
        n_ob_bytes = r_ob_bytes;
        if (ob_take) begin
            n_ob_valid    = r_ob_cnt != 3'd1;
            n_ob_cnt      = r_ob_cnt - 3'd1;
            n_ob_bytes[0] = r_ob_bytes[1];
            n_ob_bytes[1] = r_ob_bytes[2];
            n_ob_bytes[2] = r_ob_bytes[3];
            n_ob_bytes[3] = 8'h00;
        end
        if (s1_go && s1_cnt != 3'd0) begin
            n_ob_valid = 1'b1;
            n_ob_cnt   = s1_cnt;
            n_ob_fb    = s1_fb;
            n_ob_bytes = s1_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy     <= 1'b1;
            r_clr_addr     <= '0;
            r_lead_pending <= 1'b0;
            r_lead_value   <= 8'h00;
            r_name_stopped <= 1'b0;
            r_s1_valid     <= 1'b0;
            r_ob_valid     <= 1'b0;
            r_ob_cnt       <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
                if (&r_clr_addr) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_lead_pending <= n_lead_pending;
            r_lead_value   <= n_lead_value;
            r_name_stopped <= n_name_stopped;
            r_s1_valid     <= n_s1_valid;
            r_ob_valid     <= n_ob_valid;
            r_ob_cnt       <= n_ob_cnt;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_s1_lookup <= n_s1_lookup;
        r_s1_key    <= n_s1_key;
        r_ob_fb     <= n_ob_fb;
        r_ob_bytes  <= n_ob_bytes;
    end

    assign o_m_tvalid = r_ob_valid;
    assign o_m_tdata  = r_ob_bytes[0];
    assign o_m_tlast  = r_ob_cnt == 3'd1;
    assign o_m_tuser  = r_ob_fb;

endmodule
